// ===== rtl/esp_pkg.sv =====
`default_nettype none
package esp_pkg;

   localparam int MAX_POINTS  = 20;
   localparam int INDEX_W     = 6;
   localparam int COUNT_W     = 20;
   localparam int COORD_W     = 32;
   localparam int DIV_STEPS   = 16;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int REQ_DATA_W  = 296;
   localparam int RSP_DATA_W  = 176;

   localparam logic [16:0] RATIO_LIMIT = 17'd65601;
   localparam logic [32:0] ONE_Q16     = 33'd65536;
   localparam logic [32:0] POWER_MAX   = 33'h1_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_DIST,
      ST_POS,
      ST_LOAD
   } esp_state_type;

   typedef struct packed {
      logic load_item;
      logic start_point;
      logic div_step;
      logic mul_step;
      logic dist_step;
      logic pos_step;
      logic load_out;
   } esp_cmd_type;

   typedef struct packed {
      logic skip;
      logic div_done;
      logic last;
      logic out_free;
   } esp_status_type;

endpackage
`default_nettype wire

// ===== rtl/esp_ctrl.sv =====
`default_nettype none
module esp_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  esp_pkg::esp_status_type status,
   output esp_pkg::esp_cmd_type  cmd
);
   import esp_pkg::*;

   esp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.skip ? ST_IDLE : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_MUL;
         end
         ST_MUL:  state_in = ST_DIST;
         ST_DIST: state_in = ST_POS;
         ST_POS:  state_in = ST_LOAD;
         ST_LOAD: begin
            if (status.out_free) state_in = status.last ? ST_IDLE : ST_DIV;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         ST_CHECK: cmd.start_point = !status.skip;
         ST_DIV:   cmd.div_step    = 1'b1;
         ST_MUL:   cmd.mul_step    = 1'b1;
         ST_DIST:  cmd.dist_step   = 1'b1;
         ST_POS:   cmd.pos_step    = 1'b1;
         ST_LOAD: begin
            cmd.load_out    = status.out_free;
            cmd.start_point = status.out_free && !status.last;
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/esp_datapath.sv =====
`default_nettype none
module esp_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire [esp_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [esp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   input  esp_pkg::esp_cmd_type             cmd,
   output esp_pkg::esp_status_type          status
);
   import esp_pkg::*;

   // edge item
   logic [31:0]        len_ff, rad_ff;
   logic [16:0]        ratio_ff;
   logic [15:0]        vid_ff;
   logic [31:0]        start_ff [3];
   logic signed [32:0] diff_ff  [3];
   logic               skip_ff;

   // progression
   logic [32:0]        pw_ff;
   logic [31:0]        dist_ff, dist_next_ff;
   logic [INDEX_W-1:0] n_ff;
   logic               last_ff;

   // divider
   logic [31:0]          rem_ff;
   logic [15:0]          quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   // products
   logic signed [49:0] lerp_ff [3];
   logic [31:0]        pos_ff  [3];

   // output item
   logic               out_valid_ff;
   logic [COUNT_W-1:0] counter_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic               out_last_ff;

   logic [35:0] rad_x10, len_x9;
   logic [32:0] rem_sh;
   logic        rem_ge;
   logic [49:0] pw_prod;
   logic [32:0] pw_in;
   logic [47:0] dist_prod;
   logic [31:0] dist_in;
   logic [INDEX_W:0] n_plus;
   logic        last_in;

   assign rad_x10 = {1'b0, req_tdata[63:32], 3'b000} + {3'b000, req_tdata[63:32], 1'b0};
   assign len_x9  = {1'b0, req_tdata[31:0], 3'b000} + {4'b0000, req_tdata[31:0]};

   assign rem_sh = {rem_ff, 1'b0};
   assign rem_ge = rem_sh >= {1'b0, len_ff};

   assign pw_prod = pw_ff * ratio_ff;
   assign pw_in   = (pw_prod[49:16] > {1'b0, POWER_MAX}) ? POWER_MAX : pw_prod[48:16];

   // power of exactly 2^32 scales the radius by 65536
   assign dist_prod = pw_ff[32] ? {rad_ff, 16'h0000} : 48'((64'(rad_ff) * pw_ff[31:0]) >> 16);
   assign dist_in   = (dist_prod[47:32] != 16'h0000) ? 32'hFFFF_FFFF : dist_prod[31:0];

   assign n_plus  = {1'b0, n_ff} + {{INDEX_W{1'b0}}, 1'b1};
   assign last_in = (ratio_ff <= RATIO_LIMIT) || (n_plus >= (INDEX_W+1)'(MAX_POINTS))
                    || (dist_next_ff >= len_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         len_ff      <= req_tdata[31:0];
         rad_ff      <= req_tdata[63:32];
         ratio_ff    <= req_tdata[80:64];
         vid_ff      <= req_tdata[288:273];
         dist_ff     <= req_tdata[63:32];
         pw_ff       <= ONE_Q16;
         skip_ff     <= (req_tdata[63:32] == 32'h0) || (rad_x10 >= len_x9);
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= req_tdata[81+32*i +: 32];
            diff_ff[i]  <= $signed({req_tdata[177+32*i+31], req_tdata[177+32*i +: 32]})
                         - $signed({req_tdata[81+32*i+31], req_tdata[81+32*i +: 32]});
         end
      end
      if (cmd.load_item) begin
         n_ff <= '0;
      end else if (cmd.load_out) begin
         n_ff    <= n_plus[INDEX_W-1:0];
         dist_ff <= dist_next_ff;
      end

      if (cmd.start_point) begin
         rem_ff <= cmd.load_out ? dist_next_ff : dist_ff;
         quo_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? 32'(rem_sh - {1'b0, len_ff}) : rem_sh[31:0];
         quo_ff <= {quo_ff[14:0], rem_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end

      if (cmd.mul_step) begin
         pw_ff <= pw_in;
         for (int i = 0; i < 3; i++) begin
            lerp_ff[i] <= diff_ff[i] * $signed({1'b0, quo_ff});
         end
      end
      if (cmd.dist_step) begin
         dist_next_ff <= dist_in;
         for (int i = 0; i < 3; i++) begin
            // floor of the scaled step is an arithmetic shift
            pos_ff[i] <= start_ff[i] + lerp_ff[i][47:16];
         end
      end
      if (cmd.pos_step) begin
         last_ff <= last_in;
      end

      if (cmd.load_out) begin
         out_data_ff <= {6'b000000, pos_ff[2], pos_ff[1], pos_ff[0], n_ff, dist_ff,
                         vid_ff, counter_ff};
         out_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         counter_ff   <= '0;
      end else begin
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
            counter_ff   <= counter_ff + 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.skip     = skip_ff;
   assign status.div_done = cmd.div_step && (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign status.last     = last_ff;
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// ===== rtl/edge_steiner_point_placer.sv =====
// Each edge that is not skipped yields its point items one after another: a bit-serial t = distance/length
// divider (16-bit quotient), then the power and lerp products, next distance, position and last check.
// One edge is handled at a time, with at most 20 points; a skipped edge returns to idle after the check.
// Output backpressure stalls the block at the point hand-off.
// Reset (synchronous, active high) clears the controller, the output valid and the point id.
`default_nettype none
module edge_steiner_point_placer (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // length, radius, ratio, start_x, start_y, start_z, end_x, end_y, end_z, source vertex
   input  wire [esp_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // point_id, source_id, point_distance, point_index, pos_x, pos_y, pos_z
   output logic [esp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);
   import esp_pkg::*;

   esp_cmd_type    cmd;
   esp_status_type status;

   esp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   esp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

// ===== rtl/esp_checker.sv =====
`default_nettype none
module esp_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire [esp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [esp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire                              rsp_tlast
);
   import esp_pkg::*;

   logic                rsp_acc;
   logic                seen_ff;
   logic [COUNT_W-1:0]  prev_id_ff;
   logic [INDEX_W-1:0]  prev_idx_ff;
   logic                prev_last_ff;

   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_acc) begin
         seen_ff <= 1'b1;
      end
      if (rsp_acc) begin
         prev_id_ff   <= rsp_tdata[19:0];
         prev_idx_ff  <= rsp_tdata[73:68];
         prev_last_ff <= rsp_tlast;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_id_run: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && seen_ff |-> rsp_tdata[19:0] == prev_id_ff + 1'b1)
      else $error("point id not consecutive");

   a_index_run: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && seen_ff |->
         (prev_last_ff ? (rsp_tdata[73:68] == '0) : (rsp_tdata[73:68] == prev_idx_ff + 1'b1)))
      else $error("point index out of sequence");

   a_index_max: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> ({1'b0, rsp_tdata[73:68]} < (INDEX_W+1)'(MAX_POINTS)))
      else $error("too many points for one edge");

   a_one_edge: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("edge accepted while busy");

endmodule

bind edge_steiner_point_placer esp_checker u_esp_checker (.*);
`default_nettype wire
